// ===== src/rsce_pkg.sv =====
// Shared constants and codes for the route schedule cost evaluator.
// No dependencies; the core and the checker refer to it by scoped names.
`timescale 1ns / 1ps

package rsce_pkg;

    // Table sizing
    localparam int MAX_JOBS      = 256;
    localparam int HORIZON_SLOTS = 1024;
    localparam int SETUP_BITS    = 10;

    localparam int JOB_AW   = $clog2(MAX_JOBS);
    localparam int SETUP_AW = 2 * JOB_AW;
    localparam int START_AW = $clog2(HORIZON_SLOTS);
    localparam logic [SETUP_BITS-1:0] SETUP_MAX = {SETUP_BITS{1'b1}};

    // Earliest start: previous end (11 bits) plus setup, one carry bit
    localparam int EARLY_W = ((SETUP_BITS > 11) ? SETUP_BITS : 11) + 1;

    // Field widths
    localparam int SLOT_W  = 10;
    localparam int END_W   = 11;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 16;
    localparam int UW_W    = 40;
    localparam int CW_W    = 24;
    localparam int FRAC_W  = 24;
    localparam int PROD_W  = 56;
    localparam int COST_W  = 63;

    // Request types
    localparam logic [1:0] REQ_JOB   = 2'd0;
    localparam logic [1:0] REQ_SETUP = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNALLOC_W   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPL_W     = 2'd3;

endpackage

// ===== src/rsce_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on nothing; widths follow the item fields.
`timescale 1ns / 1ps

interface rsce_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  job_index;
    logic [9:0]  release_slot;
    logic [9:0]  duration_slots;
    logic [10:0] due_slot;
    logic        last_job;
    logic [9:0]  table_row;
    logic [7:0]  table_col;
    logic [10:0] table_value;

    modport source (output valid, req_type, job_index, release_slot, duration_slots,
                    due_slot, last_job, table_row, table_col, table_value,
                    input ready);
    modport sink   (input valid, req_type, job_index, release_slot, duration_slots,
                    due_slot, last_job, table_row, table_col, table_value,
                    output ready);
    modport mon    (input valid, ready, req_type, job_index, release_slot,
                    duration_slots, due_slot, last_job, table_row, table_col,
                    table_value);
endinterface

interface rsce_res_if;
    logic        valid;
    logic        ready;
    logic        allocated;
    logic [9:0]  job_start;
    logic [10:0] job_end;
    logic        route_done;
    logic [31:0] tardiness_total;
    logic [15:0] unallocated_total;
    logic [31:0] completion_total;
    logic [62:0] route_cost;

    modport source (output valid, allocated, job_start, job_end, route_done,
                    tardiness_total, unallocated_total, completion_total, route_cost,
                    input ready);
    modport sink   (input valid, allocated, job_start, job_end, route_done,
                    tardiness_total, unallocated_total, completion_total, route_cost,
                    output ready);
    modport mon    (input valid, ready, allocated, job_start, job_end, route_done,
                    tardiness_total, unallocated_total, completion_total, route_cost);
endinterface

// ===== src/route_schedule_cost_evaluator_core.sv =====
// A job beat's result is registered through stage 1, stage 2, stage 3, stage 4 and the output register.
// Jobs do not overlap: a new job waits until the loop of setup-table read, earliest-start
// max, start-table read and the route state update is through; table-write beats go one per cycle.
// The result side has three registered stages, so stalls there do not block table writes.
// Reset (rst_n, asynchronous, active low) clears the route state, pipeline valids and
// sets the configuration registers to their defaults; table memories are not cleared.
`timescale 1ns / 1ps

module route_schedule_cost_evaluator_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    rsce_req_if.sink                               req,
    rsce_res_if.source                             res,
    input  logic                                   wr_en,
    input  logic [rsce_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [rsce_pkg::CFG_DATA_W-1:0]        wr_data
);

    // Configuration registers
    logic [rsce_pkg::SLOT_W-1:0] horizon_reg;
    logic [rsce_pkg::SLOT_W-1:0] first_start_reg;
    logic [rsce_pkg::UW_W-1:0]   unalloc_w_reg;
    logic [rsce_pkg::CW_W-1:0]   compl_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg     <= rsce_pkg::SLOT_W'(1023);
            first_start_reg <= '0;
            unalloc_w_reg   <= rsce_pkg::UW_W'(64'd16777216);
            compl_w_reg     <= rsce_pkg::CW_W'(1678);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rsce_pkg::CFG_HORIZON:     horizon_reg     <= wr_data[rsce_pkg::SLOT_W-1:0];
                rsce_pkg::CFG_FIRST_START: first_start_reg <= wr_data[rsce_pkg::SLOT_W-1:0];
                rsce_pkg::CFG_UNALLOC_W:   unalloc_w_reg   <= wr_data[rsce_pkg::UW_W-1:0];
                rsce_pkg::CFG_COMPL_W:     compl_w_reg     <= wr_data[rsce_pkg::CW_W-1:0];
            endcase
        end
    end

    // Route state
    logic [7:0]                   prev_job_reg,  prev_job_next;
    logic [rsce_pkg::END_W-1:0]   prev_end_reg,  prev_end_next;
    logic [rsce_pkg::SUM_W-1:0]   tard_reg,      tard_next;
    logic [rsce_pkg::CNT_W-1:0]   cnt_reg,       cnt_next;
    logic [rsce_pkg::SUM_W-1:0]   compl_reg,     compl_next;

    // Pipeline valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s3_valid_next, s4_valid_next, out_valid_next, s2_valid_next;

    // Input handshake: a job waits until the previous job has left the update stage
    logic req_is_job, job_free, req_acc, job_acc, setup_we, start_we;

    assign req_is_job = (req.req_type == rsce_pkg::REQ_JOB);
    assign job_free   = !s1_valid_reg && !s2_valid_reg;
    assign req.ready  = !req_is_job || job_free;
    assign req_acc    = req.valid && req.ready;
    assign job_acc    = req_acc && req_is_job;
    assign setup_we   = req_acc && (req.req_type == rsce_pkg::REQ_SETUP)
                        && (32'(req.table_row) < rsce_pkg::MAX_JOBS)
                        && (32'(req.table_col) < rsce_pkg::MAX_JOBS);
    assign start_we   = req_acc && (req.req_type == rsce_pkg::REQ_START)
                        && (32'(req.table_row) < rsce_pkg::HORIZON_SLOTS);

    // Setup table memory: written by table beats, read at job accept
    logic [rsce_pkg::SETUP_BITS-1:0] setup_mem [rsce_pkg::MAX_JOBS * rsce_pkg::MAX_JOBS];
    logic [rsce_pkg::SETUP_BITS-1:0] setup_rdata;
    logic [rsce_pkg::SETUP_BITS-1:0] setup_wdata;
    logic [rsce_pkg::SETUP_AW-1:0]   setup_waddr, setup_raddr;

    assign setup_wdata = (32'(req.table_value) > 32'(rsce_pkg::SETUP_MAX))
                         ? rsce_pkg::SETUP_MAX
                         : rsce_pkg::SETUP_BITS'(req.table_value);
    assign setup_waddr = {rsce_pkg::JOB_AW'(req.table_row), rsce_pkg::JOB_AW'(req.table_col)};
    assign setup_raddr = {rsce_pkg::JOB_AW'(prev_job_reg), rsce_pkg::JOB_AW'(req.job_index)};

    always_ff @(posedge clk)
    begin
        if (setup_we)
            setup_mem[setup_waddr] <= setup_wdata;
        if (job_acc)
            setup_rdata <= setup_mem[setup_raddr];
    end

    // Stage 1 registers: job fields while the setup read completes
    logic [7:0]  s1_idx_reg;
    logic [9:0]  s1_release_reg, s1_proc_reg;
    logic [10:0] s1_due_reg;
    logic        s1_last_reg, s1_setup_ok_reg;

    always_ff @(posedge clk)
    begin
        if (job_acc)
        begin
            s1_idx_reg      <= req.job_index;
            s1_release_reg  <= req.release_slot;
            s1_proc_reg     <= req.duration_slots;
            s1_due_reg      <= req.due_slot;
            s1_last_reg     <= req.last_job;
            s1_setup_ok_reg <= (prev_job_reg != 8'd0)
                               && (32'(prev_job_reg) < rsce_pkg::MAX_JOBS)
                               && (32'(req.job_index) < rsce_pkg::MAX_JOBS);
        end
    end

    // Earliest start: max of previous end plus setup, release slot and first slot
    logic [rsce_pkg::EARLY_W-1:0] setup_ext, chain_early, early_a, earliest;
    logic                         early_ok;

    always_comb
    begin
        setup_ext   = s1_setup_ok_reg ? rsce_pkg::EARLY_W'(setup_rdata) : '0;
        chain_early = rsce_pkg::EARLY_W'(prev_end_reg) + setup_ext;
        early_a     = (rsce_pkg::EARLY_W'(s1_release_reg) > chain_early)
                      ? rsce_pkg::EARLY_W'(s1_release_reg) : chain_early;
        earliest    = (rsce_pkg::EARLY_W'(first_start_reg) > early_a)
                      ? rsce_pkg::EARLY_W'(first_start_reg) : early_a;
        early_ok    = (earliest <= rsce_pkg::EARLY_W'(horizon_reg))
                      && (32'(earliest) < rsce_pkg::HORIZON_SLOTS);
    end

    // Start table memory: read data holds while stage 2 waits
    logic [10:0]                   start_mem [rsce_pkg::HORIZON_SLOTS];
    logic [10:0]                   start_rdata;
    logic [rsce_pkg::START_AW-1:0] start_waddr, start_raddr;

    assign start_waddr = rsce_pkg::START_AW'(req.table_row);
    assign start_raddr = rsce_pkg::START_AW'(earliest);

    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_waddr] <= req.table_value;
        if (s1_valid_reg)
            start_rdata <= start_mem[start_raddr];
    end

    // Stage 2 registers
    logic [7:0]  s2_idx_reg;
    logic [9:0]  s2_proc_reg;
    logic [10:0] s2_due_reg;
    logic        s2_last_reg, s2_early_ok_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_idx_reg      <= s1_idx_reg;
            s2_proc_reg     <= s1_proc_reg;
            s2_due_reg      <= s1_due_reg;
            s2_last_reg     <= s1_last_reg;
            s2_early_ok_reg <= early_ok;
        end
    end

    // Stage 2 update: allocation, end slot and saturating sums
    logic                       out_free, s4_free, s3_free, s2_fire, s2_emit;
    logic                       s2_real, s2_alloc;
    logic [rsce_pkg::END_W-1:0] end_v, late_v;
    logic [rsce_pkg::SUM_W:0]   tard_sum, compl_sum;
    logic [rsce_pkg::SUM_W-1:0] tard_upd, compl_upd;
    logic [rsce_pkg::CNT_W-1:0] cnt_upd;

    assign out_free = !out_valid_reg || res.ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_fire  = s2_valid_reg && s3_free;
    assign s2_real  = (s2_idx_reg != 8'd0);
    assign s2_emit  = s2_fire && (s2_real || s2_last_reg);

    always_comb
    begin
        s2_alloc  = s2_real && s2_early_ok_reg && (start_rdata <= 11'(horizon_reg));
        end_v     = rsce_pkg::END_W'(start_rdata[9:0]) + rsce_pkg::END_W'(s2_proc_reg);
        late_v    = (end_v > s2_due_reg) ? (end_v - s2_due_reg) : '0;
        tard_sum  = {1'b0, tard_reg} + 33'(late_v);
        compl_sum = {1'b0, compl_reg} + 33'(end_v);

        tard_upd      = tard_reg;
        compl_upd     = compl_reg;
        cnt_upd       = cnt_reg;
        prev_job_next = prev_job_reg;
        prev_end_next = prev_end_reg;
        if (s2_alloc)
        begin
            tard_upd      = tard_sum[rsce_pkg::SUM_W] ? '1 : tard_sum[rsce_pkg::SUM_W-1:0];
            compl_upd     = compl_sum[rsce_pkg::SUM_W] ? '1 : compl_sum[rsce_pkg::SUM_W-1:0];
            prev_job_next = s2_idx_reg;
            prev_end_next = end_v;
        end
        else if (s2_real && (cnt_reg != '1))
        begin
            cnt_upd = cnt_reg + 1'b1;
        end

        // Last job of the route clears the running state
        tard_next  = tard_upd;
        compl_next = compl_upd;
        cnt_next   = cnt_upd;
        if (s2_last_reg)
        begin
            tard_next     = '0;
            compl_next    = '0;
            cnt_next      = '0;
            prev_job_next = '0;
            prev_end_next = '0;
        end
    end

    // Control state and valids
    assign s2_valid_next  = s1_valid_reg ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);
    assign s3_valid_next  = s3_free ? s2_emit : 1'b1;
    assign s4_valid_next  = s4_free ? s3_valid_reg : 1'b1;
    assign out_valid_next = out_free ? s4_valid_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_job_reg  <= '0;
            prev_end_reg  <= '0;
            tard_reg      <= '0;
            cnt_reg       <= '0;
            compl_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= job_acc;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_fire)
            begin
                prev_job_reg <= prev_job_next;
                prev_end_reg <= prev_end_next;
                tard_reg     <= tard_next;
                cnt_reg      <= cnt_next;
                compl_reg    <= compl_next;
            end
        end
    end

    // Stage 3: result fields and totals (totals only on the route's last beat)
    logic                       s3_alloc_reg, s3_done_reg;
    logic [9:0]                 s3_start_reg;
    logic [10:0]                s3_end_reg;
    logic [rsce_pkg::SUM_W-1:0] s3_tard_reg, s3_compl_reg;
    logic [rsce_pkg::CNT_W-1:0] s3_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (s2_emit)
        begin
            s3_alloc_reg <= s2_alloc;
            s3_start_reg <= s2_alloc ? start_rdata[9:0] : '0;
            s3_end_reg   <= s2_alloc ? end_v : '0;
            s3_done_reg  <= s2_last_reg;
            s3_tard_reg  <= s2_last_reg ? tard_upd : '0;
            s3_cnt_reg   <= s2_last_reg ? cnt_upd : '0;
            s3_compl_reg <= s2_last_reg ? compl_upd : '0;
        end
    end

    // Stage 4: weight products
    logic                        s4_alloc_reg, s4_done_reg;
    logic [9:0]                  s4_start_reg;
    logic [10:0]                 s4_end_reg;
    logic [rsce_pkg::SUM_W-1:0]  s4_tard_reg, s4_compl_reg;
    logic [rsce_pkg::CNT_W-1:0]  s4_cnt_reg;
    logic [rsce_pkg::PROD_W-1:0] s4_pu_reg, s4_pc_reg;

    always_ff @(posedge clk)
    begin
        if (s4_free && s3_valid_reg)
        begin
            s4_alloc_reg <= s3_alloc_reg;
            s4_start_reg <= s3_start_reg;
            s4_end_reg   <= s3_end_reg;
            s4_done_reg  <= s3_done_reg;
            s4_tard_reg  <= s3_tard_reg;
            s4_cnt_reg   <= s3_cnt_reg;
            s4_compl_reg <= s3_compl_reg;
            s4_pu_reg    <= rsce_pkg::PROD_W'(unalloc_w_reg) * rsce_pkg::PROD_W'(s3_cnt_reg);
            s4_pc_reg    <= rsce_pkg::PROD_W'(compl_w_reg) * rsce_pkg::PROD_W'(s3_compl_reg);
        end
    end

    // Output register: cost sum; three 56-bit terms stay far below the 63-bit limit
    logic                        out_alloc_reg, out_done_reg;
    logic [9:0]                  out_start_reg;
    logic [10:0]                 out_end_reg;
    logic [rsce_pkg::SUM_W-1:0]  out_tard_reg, out_compl_reg;
    logic [rsce_pkg::CNT_W-1:0]  out_cnt_reg;
    logic [rsce_pkg::COST_W-1:0] out_cost_reg, cost_next;

    assign cost_next = (rsce_pkg::COST_W'(s4_tard_reg) << rsce_pkg::FRAC_W)
                       + rsce_pkg::COST_W'(s4_pu_reg)
                       + rsce_pkg::COST_W'(s4_pc_reg);

    always_ff @(posedge clk)
    begin
        if (out_free && s4_valid_reg)
        begin
            out_alloc_reg <= s4_alloc_reg;
            out_start_reg <= s4_start_reg;
            out_end_reg   <= s4_end_reg;
            out_done_reg  <= s4_done_reg;
            out_tard_reg  <= s4_tard_reg;
            out_cnt_reg   <= s4_cnt_reg;
            out_compl_reg <= s4_compl_reg;
            out_cost_reg  <= cost_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.allocated         = out_alloc_reg;
    assign res.job_start         = out_start_reg;
    assign res.job_end           = out_end_reg;
    assign res.route_done        = out_done_reg;
    assign res.tardiness_total   = out_tard_reg;
    assign res.unallocated_total = out_cnt_reg;
    assign res.completion_total  = out_compl_reg;
    assign res.route_cost        = out_cost_reg;

endmodule

// ===== src/rsce_checker.sv =====
// Port-level checks for the route schedule cost evaluator, bound to the top level.
// Depends on rsce_pkg; the bind taps the request and result channel signals.
`timescale 1ns / 1ps

module rsce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_type,
    input logic        res_valid,
    input logic        res_ready,
    input logic        allocated,
    input logic [9:0]  job_start,
    input logic [10:0] job_end,
    input logic        route_done,
    input logic [31:0] tardiness_total,
    input logic [15:0] unallocated_total,
    input logic [31:0] completion_total,
    input logic [62:0] route_cost
);

    logic job_beat;

    assign job_beat = req_valid && req_ready && (req_type == rsce_pkg::REQ_JOB);

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(job_end)
                                    && $stable(route_cost) && $stable(allocated))
    else $error("result beat changed while stalled");

    // No job beat is accepted while the previous job is still in the update loop
    assert property (@(posedge clk) disable iff (!rst_n)
        job_beat |=> !job_beat ##1 !job_beat)
    else $error("job beat accepted inside the update loop");

    // Totals only appear on the route's last result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !route_done |-> tardiness_total == '0
            && unallocated_total == '0 && completion_total == '0
            && route_cost == '0)
    else $error("totals on a result that does not close the route");

    // An unallocated job carries no start or end, an allocated one ends at or after start
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (allocated ? (job_end >= 11'(job_start))
                                 : (job_start == '0 && job_end == '0)))
    else $error("start and end slots inconsistent with allocation");

endmodule

bind route_schedule_cost_evaluator_core rsce_checker u_rsce_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_type          (req.req_type),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .allocated         (res.allocated),
    .job_start         (res.job_start),
    .job_end           (res.job_end),
    .route_done        (res.route_done),
    .tardiness_total   (res.tardiness_total),
    .unallocated_total (res.unallocated_total),
    .completion_total  (res.completion_total),
    .route_cost        (res.route_cost)
);
